// ===== rtl/fcdma_pkg.sv =====
// Shared types and codes for the four-channel DMA controller.
package fcdma_pkg;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_XFER  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		SEL_ADDR   = 3'd0,
		SEL_COUNT  = 3'd1,
		SEL_STATUS = 3'd2,
		SEL_MODE   = 3'd3,
		SEL_MASK   = 3'd4,
		SEL_CLR_FF = 3'd5,
		SEL_MRESET = 3'd6,
		SEL_NONE   = 3'd7
	} sel_t;

	localparam logic [1:0] XFER_TYPE_TO_MEM = 2'b01;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] reg_select;
		logic [1:0] channel;
		logic [7:0] write_data;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        xfer_valid;
		logic [15:0] xfer_address;
		logic        xfer_to_memory;
		logic        terminal_count;
	} result_t;

endpackage

// ===== rtl/fcdma_if.sv =====
// Valid/ready channel interface carrying one payload.
interface fcdma_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/four_channel_dma_controller_core.sv =====
// Four-channel DMA controller core: register file, transfer engine, result register.
//
// One item (register write, register read or transfer request) is taken per clock
// cycle; its result appears in the output register on the next cycle and the
// next item is accepted in the same cycle as long as that register is empty or
// being drained. All channel state lives in flip-flops updated in one pass.
module four_channel_dma_controller_core #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic clk,
	input  logic arst_n,
	fcdma_if.sink   in_ch,
	fcdma_if.source out_ch
);
	localparam logic [NUM_CHANNELS-1:0] ALL_MASK = '1;

	logic [15:0] base_address_q    [NUM_CHANNELS];
	logic [15:0] current_address_q [NUM_CHANNELS];
	logic [15:0] base_count_q      [NUM_CHANNELS];
	logic [15:0] current_count_q   [NUM_CHANNELS];
	logic [5:0]  channel_mode_q    [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] mask_q, tc_status_q;
	logic        flipflop_q;
	logic [7:0]  command_q;

	fcdma_pkg::item_t   item;
	fcdma_pkg::result_t res, res_q;
	logic               out_valid_q;
	logic               accept;

	assign item        = in_ch.payload;
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = res_q;

	logic ch_ok, dch_ok, is_wr, is_rd, is_xf, port_sel, do_xfer, wrap;
	logic [1:0]  dch;
	logic [15:0] cur_a, cur_c;
	logic [NUM_CHANNELS-1:0] ch_bit, dch_bit;

	always_comb begin
		ch_ok   = 32'(item.channel) < NUM_CHANNELS;
		dch     = item.write_data[1:0];
		dch_ok  = 32'(dch) < NUM_CHANNELS;
		ch_bit  = ch_ok  ? NUM_CHANNELS'(1) << item.channel : '0;
		dch_bit = dch_ok ? NUM_CHANNELS'(1) << dch : '0;
		is_wr   = item.kind == fcdma_pkg::KIND_WRITE;
		is_rd   = item.kind == fcdma_pkg::KIND_READ;
		is_xf   = item.kind == fcdma_pkg::KIND_XFER;
		port_sel = item.reg_select == fcdma_pkg::SEL_ADDR
			|| item.reg_select == fcdma_pkg::SEL_COUNT;
		cur_a = '0;
		cur_c = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (ch_bit[i]) begin
				cur_a = current_address_q[i];
				cur_c = current_count_q[i];
			end
		end
		do_xfer = is_xf && ch_ok && ((mask_q & ch_bit) == '0);
		wrap    = cur_c == '0;

		res = '0;
		if (is_rd) begin
			case (item.reg_select)
				fcdma_pkg::SEL_ADDR:
					if (ch_ok) res.read_data = flipflop_q ? cur_a[15:8] : cur_a[7:0];
				fcdma_pkg::SEL_COUNT:
					if (ch_ok) res.read_data = flipflop_q ? cur_c[15:8] : cur_c[7:0];
				fcdma_pkg::SEL_STATUS: res.read_data = 8'(tc_status_q) & 8'h0F;
				default: res.read_data = '0;
			endcase
		end
		if (do_xfer) begin
			res.xfer_valid     = 1'b1;
			res.xfer_address   = cur_a;
			res.terminal_count = wrap;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch_bit[i])
					res.xfer_to_memory = channel_mode_q[i][1:0] == fcdma_pkg::XFER_TYPE_TO_MEM;
			end
		end
	end

	// Per-channel payload registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				base_address_q[i]    <= '0;
				current_address_q[i] <= '0;
				base_count_q[i]      <= '0;
				current_count_q[i]   <= '0;
				channel_mode_q[i]    <= '0;
			end
		end else if (accept) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (ch_bit[i] && is_wr && item.reg_select == fcdma_pkg::SEL_ADDR) begin
					if (flipflop_q) begin
						base_address_q[i][15:8]    <= item.write_data;
						current_address_q[i][15:8] <= item.write_data;
					end else begin
						base_address_q[i][7:0]    <= item.write_data;
						current_address_q[i][7:0] <= item.write_data;
					end
				end
				if (ch_bit[i] && is_wr && item.reg_select == fcdma_pkg::SEL_COUNT) begin
					if (flipflop_q) begin
						base_count_q[i][15:8]    <= item.write_data;
						current_count_q[i][15:8] <= item.write_data;
					end else begin
						base_count_q[i][7:0]    <= item.write_data;
						current_count_q[i][7:0] <= item.write_data;
					end
				end
				if (dch_bit[i] && is_wr && item.reg_select == fcdma_pkg::SEL_MODE)
					channel_mode_q[i] <= item.write_data[7:2];
				if (ch_bit[i] && do_xfer) begin
					current_address_q[i] <= cur_a + 16'd1;
					current_count_q[i]   <= cur_c - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= ALL_MASK;
			tc_status_q <= '0;
			flipflop_q  <= 1'b0;
			command_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			if (accept) begin
				if ((is_wr || is_rd) && port_sel) flipflop_q <= !flipflop_q;
				if (is_wr) begin
					case (item.reg_select)
						fcdma_pkg::SEL_STATUS: command_q <= item.write_data;
						fcdma_pkg::SEL_MASK:
							mask_q <= item.write_data[2] ? (mask_q | dch_bit)
								: (mask_q & ~dch_bit);
						fcdma_pkg::SEL_CLR_FF: flipflop_q <= 1'b0;
						fcdma_pkg::SEL_MRESET: begin
							flipflop_q  <= 1'b0;
							tc_status_q <= '0;
							command_q   <= '0;
							mask_q      <= ALL_MASK;
						end
						default: ;
					endcase
				end
				if (is_rd && item.reg_select == fcdma_pkg::SEL_STATUS) tc_status_q <= '0;
				if (do_xfer && wrap) begin
					tc_status_q <= tc_status_q | ch_bit;
					mask_q      <= mask_q | ch_bit;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(res_q))
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && do_xfer && wrap
		|=> mask_q[$past(item.channel)] && tc_status_q[$past(item.channel)])
		else $error("terminal count did not mask channel");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.terminal_count |-> res_q.xfer_valid)
		else $error("terminal count without transfer");
endmodule
